@@ src/lfpd_pkg.sv @@
// Package for the line-follow PD steering framer.
// Holds the configuration, command and status types and the frame constants.
// No dependencies.
package lfpd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_FORWARD_SPEED      = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN          = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN         = 3'd2;
    localparam logic [2:0] REG_PRESENCE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_DEADBAND_Q8        = 3'd4;
    localparam logic [2:0] REG_BIAS_SCALE         = 3'd5;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    // Reset values of the configuration registers.
    localparam logic signed [15:0] FORWARD_SPEED_RST      = 16'sd3500;
    localparam logic [9:0]         PROP_GAIN_RST          = 10'd280;
    localparam logic signed [10:0] DERIV_GAIN_RST         = -11'sd100;
    localparam logic [13:0]        PRESENCE_THRESHOLD_RST = 14'd25;
    localparam logic [13:0]        DEADBAND_Q8_RST        = 14'd128;
    localparam logic [6:0]         BIAS_SCALE_RST         = 7'd50;

    // Frame delimiters.
    localparam logic [7:0] FRAME_HEAD = 8'h5A;
    localparam logic [7:0] FRAME_TAIL = 8'hA5;

    // Byte positions within the six-byte frame.
    typedef logic [2:0] byte_idx_t;
    localparam byte_idx_t BYTE_HEAD     = 3'd0;
    localparam byte_idx_t BYTE_RIGHT_HI = 3'd1;
    localparam byte_idx_t BYTE_RIGHT_LO = 3'd2;
    localparam byte_idx_t BYTE_LEFT_HI  = 3'd3;
    localparam byte_idx_t BYTE_LEFT_LO  = 3'd4;
    localparam byte_idx_t BYTE_TAIL     = 3'd5;

    typedef struct packed {
        logic signed [15:0] forward_speed;
        logic [9:0]         prop_gain;
        logic signed [10:0] deriv_gain;
        logic [13:0]        presence_threshold;
        logic [13:0]        deadband_q8;
        logic [6:0]         bias_scale;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      bias_en;
        logic      mul_p;
        logic      mul_d;
        logic      steer_en;
        logic      wheel_en;
        byte_idx_t byte_idx;
    } lfpd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } lfpd_status_t;

endpackage

@@ src/lfpd_if.sv @@
// Channel interfaces of the line-follow PD steering framer.
// Depends on lfpd_pkg for the configuration port widths.
interface lfpd_in_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] middle_sample;
    logic [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, left_sample, middle_sample, right_sample, input ready);
    modport sink (input valid, left_sample, middle_sample, right_sample, output ready);
endinterface

interface lfpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

interface lfpd_cfg_if;
    import lfpd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/line_follow_pd_steering_framer_top.sv @@
// Top level of the line-follow PD steering framer.
// Depends on lfpd_pkg, lfpd_if, lfpd_cfg_regs, lfpd_ctrl and lfpd_dp.

// This block turns one transfer of three sensor samples into one six-byte wheel
// speed frame. It takes an item only when idle, so one item is worked at a time.
// After the accepting cycle the bias division runs (one quotient bit per cycle
// from a restoring divider), then the bias, the two PD products, the steering
// term and the saturated wheel codes are formed in turn, and then the six frame
// bytes go out, one per cycle while the sink is ready. The bias after the
// deadband is kept as the previous bias for the derivative term of the next
// item. Configuration writes are always ready and take effect at once; they
// should be made only while the block is idle.
module line_follow_pd_steering_framer_top
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input logic         clk,
    input logic         rst_n,
    lfpd_in_if.sink     samples,
    lfpd_out_if.source  frame,
    lfpd_cfg_if.sink    cfg
);

    cfg_t         cfg_values;
    lfpd_cmd_t    cmd;
    lfpd_status_t status;

    // Register file for the six configuration registers.
    lfpd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_values)
    );

    // Sequencer: accept, divide, PD steps, then the frame transfers.
    lfpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and the frame byte selection.
    lfpd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_values),
        .cmd           (cmd),
        .status        (status),
        .left_sample   (samples.left_sample),
        .middle_sample (samples.middle_sample),
        .right_sample  (samples.right_sample),
        .frame_byte    (frame.frame_byte),
        .frame_last    (frame.frame_last)
    );

endmodule

@@ src/lfpd_cfg_regs.sv @@
// Configuration register file of the line-follow PD steering framer.
// Depends on lfpd_pkg for register indexes, reset values and cfg_t.
module lfpd_cfg_regs
    import lfpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_valid,
    output logic                   wr_ready,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            case (wr_index)
                REG_FORWARD_SPEED:      cfg_next.forward_speed = wr_data;
                REG_PROP_GAIN:          cfg_next.prop_gain = wr_data[9:0];
                REG_DERIV_GAIN:         cfg_next.deriv_gain = wr_data[10:0];
                REG_PRESENCE_THRESHOLD: cfg_next.presence_threshold = wr_data[13:0];
                REG_DEADBAND_Q8:        cfg_next.deadband_q8 = wr_data[13:0];
                REG_BIAS_SCALE:         cfg_next.bias_scale = wr_data[6:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forward_speed      <= FORWARD_SPEED_RST;
            cfg_reg.prop_gain          <= PROP_GAIN_RST;
            cfg_reg.deriv_gain         <= DERIV_GAIN_RST;
            cfg_reg.presence_threshold <= PRESENCE_THRESHOLD_RST;
            cfg_reg.deadband_q8        <= DEADBAND_Q8_RST;
            cfg_reg.bias_scale         <= BIAS_SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/lfpd_ctrl.sv @@
// Controller state machine of the line-follow PD steering framer.
// Depends on lfpd_pkg for the command and status structs and byte positions.
module lfpd_ctrl
    import lfpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  lfpd_status_t status,
    output lfpd_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_BIAS  = 8'b0000_0100,
        ST_MULP  = 8'b0000_1000,
        ST_MULD  = 8'b0001_0000,
        ST_STEER = 8'b0010_0000,
        ST_WHEEL = 8'b0100_0000,
        ST_SEND  = 8'b1000_0000
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    byte_idx_t idx_reg;
    byte_idx_t idx_next;
    logic      in_xfer;
    logic      out_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS:  state_next = ST_MULP;
            ST_MULP:  state_next = ST_MULD;
            ST_MULD:  state_next = ST_STEER;
            ST_STEER: state_next = ST_WHEEL;
            ST_WHEEL:
            begin
                state_next = ST_SEND;
                idx_next   = BYTE_HEAD;
            end
            ST_SEND:
            begin
                if (out_xfer)
                begin
                    if (idx_reg == BYTE_TAIL)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = BYTE_HEAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = BYTE_HEAD;
            end
        endcase
    end

    always_comb
    begin
        cmd.load     = in_xfer;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.bias_en  = (state_reg == ST_BIAS);
        cmd.mul_p    = (state_reg == ST_MULP);
        cmd.mul_d    = (state_reg == ST_MULD);
        cmd.steer_en = (state_reg == ST_STEER);
        cmd.wheel_en = (state_reg == ST_WHEEL);
        cmd.byte_idx = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= BYTE_HEAD;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // A new item is never taken while a frame is still going out.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while frame bytes pending");

    // The closing byte transfer returns the block to idle.
    a_tail_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && idx_reg == BYTE_TAIL) |=> in_ready)
        else $error("block not idle after closing byte");

    // The byte position never passes the closing byte.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg == BYTE_HEAD || idx_reg == BYTE_RIGHT_HI || idx_reg == BYTE_RIGHT_LO ||
        idx_reg == BYTE_LEFT_HI || idx_reg == BYTE_LEFT_LO || idx_reg == BYTE_TAIL)
        else $error("frame byte position out of range");

    // An accepted item starts the division in the next cycle.
    a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> cmd.div_step)
        else $error("division did not start after accept");

endmodule

@@ src/lfpd_dp.sv @@
// Datapath of the line-follow PD steering framer: bias division, PD terms,
// wheel saturation and frame byte selection. Depends on lfpd_pkg.
module lfpd_dp
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  lfpd_cmd_t              cmd,
    output lfpd_status_t           status,
    input  logic [SAMPLE_BITS-1:0] left_sample,
    input  logic [SAMPLE_BITS-1:0] middle_sample,
    input  logic [SAMPLE_BITS-1:0] right_sample,
    output logic [7:0]             frame_byte,
    output logic                   frame_last
);

    localparam int MS_W  = SAMPLE_BITS + 7;
    localparam int NUM_W = MS_W + 8;
    localparam int DEN_W = SAMPLE_BITS + 1;
    localparam int CMP_W = (SAMPLE_BITS + 2 > 14) ? SAMPLE_BITS + 2 : 14;
    localparam int CNT_W = $clog2(NUM_W);

    // Load-time arithmetic.
    logic [CMP_W-1:0]       sample_sum;
    logic [DEN_W-1:0]       den_w;
    logic                   neg_w;
    logic [SAMPLE_BITS-1:0] mag_w;
    logic [MS_W-1:0]        scaled_w;

    // Division state.
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             steer_ok_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             fits;

    // PD and wheel state.
    logic [15:0]        q_mag;
    logic signed [15:0] bias_reg;
    logic signed [15:0] bias_next;
    logic signed [15:0] prev_reg;
    logic signed [26:0] p_reg;
    logic signed [27:0] d_reg;
    logic signed [16:0] delta;
    logic signed [28:0] pd_sum;
    logic signed [28:0] pd_adj;
    logic signed [20:0] steer_reg;
    logic signed [21:0] left_w;
    logic signed [21:0] right_w;
    logic [15:0]        lcode_reg;
    logic [15:0]        rcode_reg;

    // Saturates to int16 and applies the 0x8000 offset by flipping the sign bit.
    function automatic logic [15:0] wheel_code(input logic signed [21:0] v);
        logic signed [15:0] s;
        if (v > 22'sd32767)
        begin
            s = 16'sh7FFF;
        end
        else if (v < -22'sd32768)
        begin
            s = 16'sh8000;
        end
        else
        begin
            s = v[15:0];
        end
        return {~s[15], s[14:0]};
    endfunction

    assign sample_sum = CMP_W'(left_sample) + CMP_W'(middle_sample) + CMP_W'(right_sample);
    assign den_w      = DEN_W'(left_sample) + DEN_W'(right_sample);
    assign neg_w      = left_sample < right_sample;
    assign mag_w      = neg_w ? right_sample - left_sample : left_sample - right_sample;
    assign scaled_w   = MS_W'(mag_w) * MS_W'(cfg.bias_scale);

    // Restoring division, one quotient bit per cycle.
    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = !trial[DEN_W+1];

    assign status.div_last = (cnt_reg == CNT_W'(NUM_W - 1));

    // The quotient magnitude stays below 2^15 whenever the divisor is nonzero.
    assign q_mag = quot_reg[15:0];

    always_comb
    begin
        if (!steer_ok_reg || q_mag < {2'b00, cfg.deadband_q8})
        begin
            bias_next = 16'sd0;
        end
        else if (neg_reg)
        begin
            bias_next = -$signed(q_mag);
        end
        else
        begin
            bias_next = $signed(q_mag);
        end
    end

    assign delta   = 17'(bias_reg) - 17'(prev_reg);
    assign pd_sum  = 29'(p_reg) + 29'(d_reg);
    assign pd_adj  = pd_sum + (pd_sum[28] ? 29'sd255 : 29'sd0);
    assign left_w  = 22'(cfg.forward_speed) - 22'(steer_reg);
    assign right_w = 22'(cfg.forward_speed) + 22'(steer_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 16'sd0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.wheel_en)
            begin
                prev_reg <= bias_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg     <= {scaled_w, 8'h00};
            rem_reg      <= '0;
            den_reg      <= den_w;
            neg_reg      <= neg_w;
            steer_ok_reg <= (sample_sum > CMP_W'(cfg.presence_threshold)) && (den_w != '0);
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
        if (cmd.bias_en)
        begin
            bias_reg <= bias_next;
        end
        if (cmd.mul_p)
        begin
            p_reg <= $signed(27'(cfg.prop_gain)) * 27'(bias_reg);
        end
        if (cmd.mul_d)
        begin
            d_reg <= 28'(cfg.deriv_gain) * 28'(delta);
        end
        if (cmd.steer_en)
        begin
            steer_reg <= pd_adj[28:8];
        end
        if (cmd.wheel_en)
        begin
            lcode_reg <= wheel_code(left_w);
            rcode_reg <= wheel_code(right_w);
        end
    end

    always_comb
    begin
        case (cmd.byte_idx)
            BYTE_HEAD:     frame_byte = FRAME_HEAD;
            BYTE_RIGHT_HI: frame_byte = rcode_reg[15:8];
            BYTE_RIGHT_LO: frame_byte = rcode_reg[7:0];
            BYTE_LEFT_HI:  frame_byte = lcode_reg[15:8];
            BYTE_LEFT_LO:  frame_byte = lcode_reg[7:0];
            BYTE_TAIL:     frame_byte = FRAME_TAIL;
            default:       frame_byte = FRAME_TAIL;
        endcase
    end

    assign frame_last = (cmd.byte_idx == BYTE_TAIL);

endmodule

@@ verif/line_follow_pd_steering_framer_top_test.sv @@
`timescale 1ns / 100ps
// Testbench for the line-follow PD steering framer top level.
// Depends on lfpd_pkg, the lfpd channel interfaces and the framer RTL.

module line_follow_pd_steering_framer_top_test;
    import lfpd_pkg::*;

    // Run-wide limits. A few hundred items, each with its six frame bytes, with random
    // stalls and one long hold stay far below this.
    localparam int RUN_LIMIT     = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_PERCENT  = 9;
    localparam int SHOWN_ERRORS  = 10;

    // Register indexes that no register answers to; a write there changes nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    // One expected byte of a speed frame.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } frame_beat_t;

    logic clk;
    logic rst_n;

    lfpd_in_if #(.SAMPLE_BITS(12)) samples_if ();
    lfpd_out_if                    frame_if ();
    lfpd_cfg_if                    cfg_if ();

    line_follow_pd_steering_framer_top #(.SAMPLE_BITS(12)) DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .frame   (frame_if),
        .cfg     (cfg_if)
    );

    // Shadow copy of the block's registers and of the previous bias, in Q8.8.
    cfg_t        shadow_cfg;
    longint      prev_bias_q8;
    frame_beat_t frame_bytes_due[$];

    int  mismatches;
    int  cycle_count;
    bit  no_idle;
    int  hold_asked;
    int  hold_granted;
    int  hold_left;

    // Free-running clock, 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog. A hung handshake or a lost frame ends up here.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("line_follow_pd_steering_framer_top verification failed");
            $finish;
        end
    end

    // Saturate a wheel command to int16 and move it into offset binary.
    function automatic logic [15:0] wheel_code(input longint command);
        longint clipped;
        clipped = command;
        if (clipped > 32767)
            clipped = 32767;
        if (clipped < -32768)
            clipped = -32768;
        return 16'(clipped + 32768);
    endfunction

    // Work out the frame that one accepted set of samples must produce, and
    // advance the previous-bias state the same way the block does.
    function automatic void predict_frame(input logic [11:0] left_s, middle_s, right_s);
        longint left_v, middle_v, right_v, span, bias, steer;
        longint speed, kp, kd;
        logic [15:0] left_code, right_code;
        frame_beat_t beat;
        left_v   = left_s;
        middle_v = middle_s;
        right_v  = right_s;
        speed    = $signed(shadow_cfg.forward_speed);
        kd       = $signed(shadow_cfg.deriv_gain);
        kp       = longint'(shadow_cfg.prop_gain);
        bias     = 0;
        // The line counts as present only when the sum strictly exceeds the
        // threshold. A zero left-plus-right sum leaves the bias at zero.
        if (left_v + middle_v + right_v > longint'(shadow_cfg.presence_threshold))
        begin
            span = left_v + right_v;
            if (span != 0)
                bias = longint'(shadow_cfg.bias_scale) * (left_v - right_v) * 256 / span;
        end
        if ((bias < 0 ? -bias : bias) < longint'(shadow_cfg.deadband_q8))
            bias = 0;
        // Division by 256 truncates toward zero, as the block does.
        steer        = (kp * bias + kd * (bias - prev_bias_q8)) / 256;
        prev_bias_q8 = bias;
        left_code  = wheel_code(speed - steer);
        right_code = wheel_code(speed + steer);
        beat.frame_last = 1'b0;
        beat.frame_byte = FRAME_HEAD;        frame_bytes_due.push_back(beat);
        beat.frame_byte = right_code[15:8];  frame_bytes_due.push_back(beat);
        beat.frame_byte = right_code[7:0];   frame_bytes_due.push_back(beat);
        beat.frame_byte = left_code[15:8];   frame_bytes_due.push_back(beat);
        beat.frame_byte = left_code[7:0];    frame_bytes_due.push_back(beat);
        beat.frame_byte = FRAME_TAIL;
        beat.frame_last = 1'b1;
        frame_bytes_due.push_back(beat);
    endfunction

    // Frame sink. It stalls about 9 percent of the time unless the no-idle stretch is on,
    // and serves each hold request with a long run of cycles with ready low.
    initial
    begin
        frame_if.ready <= 1'b0;
        hold_granted = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_granted != hold_asked)
            begin
                hold_left = HOLD_CYCLES;
                hold_granted++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_if.ready <= 1'b0;
            end
            else
                frame_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Frame checker. Every byte transfer is matched against the oldest expected
    // byte; a byte with nothing expected is a failure as well.
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && frame_if.valid && frame_if.ready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: unexpected frame byte %02h last %0b", $realtime,
                             frame_if.frame_byte, frame_if.frame_last);
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (frame_if.frame_byte !== want.frame_byte ||
                    frame_if.frame_last !== want.frame_last)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("%0t: frame byte expected %02h last %0b, got %02h last %0b",
                                 $realtime, want.frame_byte, want.frame_last,
                                 frame_if.frame_byte, frame_if.frame_last);
                end
            end
        end
    end

    // Offer one set of samples and return at the edge where it transfers. Valid
    // is left high so that a following item goes out back to back; an idle gap
    // lowers it first.
    task automatic send_samples(input logic [11:0] left_s, middle_s, right_s);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid         <= 1'b1;
        samples_if.left_sample   <= left_s;
        samples_if.middle_sample <= middle_s;
        samples_if.right_sample  <= right_s;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        predict_frame(left_s, middle_s, right_s);
    endtask

    // Stop offering samples and wait until every expected byte has arrived.
    // The block is idle from then on, so registers may be written.
    task automatic wait_frames_out();
        samples_if.valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    // One register write on the configuration channel. The shadow keeps only the
    // bits that the register holds.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (index)
            REG_FORWARD_SPEED:      shadow_cfg.forward_speed      = value[15:0];
            REG_PROP_GAIN:          shadow_cfg.prop_gain          = value[9:0];
            REG_DERIV_GAIN:         shadow_cfg.deriv_gain         = value[10:0];
            REG_PRESENCE_THRESHOLD: shadow_cfg.presence_threshold = value[13:0];
            REG_DEADBAND_Q8:        shadow_cfg.deadband_q8        = value[13:0];
            REG_BIAS_SCALE:         shadow_cfg.bias_scale         = value[6:0];
            default:                ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write all six registers, one after another.
    task automatic write_setting(input int speed, kp, kd, threshold, deadband, scale);
        write_reg(REG_FORWARD_SPEED,      16'(speed));
        write_reg(REG_PROP_GAIN,          16'(kp));
        write_reg(REG_DERIV_GAIN,         16'(kd));
        write_reg(REG_PRESENCE_THRESHOLD, 16'(threshold));
        write_reg(REG_DEADBAND_Q8,        16'(deadband));
        write_reg(REG_BIAS_SCALE,         16'(scale));
    endtask

    // A register value that lands on either end of its range now and then, and
    // sometimes carries stray bits above the register width.
    function automatic logic [15:0] pick_reg_value(input int low_v, high_v, width);
        int pick;
        logic [15:0] value;
        logic [15:0] field_mask;
        case ($urandom_range(5))
            0:       pick = low_v;
            1:       pick = high_v;
            default: pick = low_v + int'($urandom_range(high_v - low_v));
        endcase
        value = 16'(pick);
        if (width < 16 && $urandom_range(3) == 0)
        begin
            field_mask = 16'((32'd1 << width) - 1);
            value = (value & field_mask) | (16'($urandom) & ~field_mask);
        end
        return value;
    endfunction

    // Random samples. Most items look like a track under the sensors: a strong
    // middle reading with random outer ones. The rest are faint readings near
    // the presence threshold, a dead left-plus-right pair, and full-range noise.
    task automatic send_random_samples();
        logic [11:0] left_s, middle_s, right_s;
        case ($urandom_range(9))
            0:
            begin
                left_s   = 12'($urandom_range(20));
                middle_s = 12'($urandom_range(20));
                right_s  = 12'($urandom_range(20));
            end
            1:
            begin
                left_s   = '0;
                middle_s = 12'($urandom);
                right_s  = '0;
            end
            2, 3:
            begin
                left_s   = 12'($urandom);
                middle_s = 12'($urandom);
                right_s  = 12'($urandom);
            end
            default:
            begin
                left_s   = 12'($urandom_range(4095));
                middle_s = 12'($urandom_range(4095, 1000));
                right_s  = 12'($urandom_range(4095));
            end
        endcase
        send_samples(left_s, middle_s, right_s);
    endtask

    // Reset settings: extremes of the samples, the line absent and just present
    // around the threshold of 25, a zero left-plus-right sum, and a bias inside
    // the deadband.
    task automatic test_reset_settings();
        send_samples(12'd0,    12'd0,    12'd0);
        send_samples(12'd0,    12'd4095, 12'd0);
        send_samples(12'd4095, 12'd0,    12'd0);
        send_samples(12'd0,    12'd0,    12'd4095);
        send_samples(12'd4095, 12'd4095, 12'd4095);
        send_samples(12'd10,   12'd10,   12'd5);
        send_samples(12'd10,   12'd10,   12'd6);
        send_samples(12'd2000, 12'd0,    12'd1999);
        send_samples(12'd2048, 12'd2048, 12'd1024);
        wait_frames_out();
    endtask

    // Register extremes. Full gains with the fastest forward speed drive both
    // wheels into saturation, then the slowest speed with a derivative gain of
    // -1024, the lowest value that its register holds. The spare indexes
    // must leave every register alone.
    task automatic test_register_extremes();
        write_setting(32767, 1023, 1023, 0, 0, 127);
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'hFFFF);
        send_samples(12'd4095, 12'd0, 12'd0);
        send_samples(12'd0,    12'd0, 12'd4095);
        send_samples(12'd1,    12'd0, 12'd0);
        send_samples(12'd0,    12'd0, 12'd1);
        wait_frames_out();

        write_setting(-32768, 1023, -1024, 12284, 16383, 127);
        send_samples(12'd4095, 12'd4095, 12'd0);
        send_samples(12'd4095, 12'd4095, 12'd4095);
        send_samples(12'd0,    12'd4095, 12'd4095);
        wait_frames_out();

        // Zero gains and zero scale give a flat frame; the threshold register is
        // loaded with all of its bits set.
        write_setting(0, 0, 0, 16383, 0, 0);
        send_samples(12'd4095, 12'd4095, 12'd4095);
        wait_frames_out();
        write_reg(REG_PRESENCE_THRESHOLD, 16'd0);
        send_samples(12'd4095, 12'd1, 12'd0);
        send_samples(12'd0,    12'd1, 12'd4095);
        wait_frames_out();
    endtask

    // A stretch with no idling on either side, so items follow one another at
    // the block's own pace.
    task automatic test_back_to_back();
        write_setting(1200, 600, 300, 100, 64, 90);
        no_idle = 1'b1;
        repeat (40)
            send_random_samples();
        wait_frames_out();
        no_idle = 1'b0;
    endtask

    // The sink holds off for a long stretch while samples keep coming, so the
    // block fills up and stalls its input. Then the source pauses until every
    // frame is out.
    task automatic test_output_hold();
        hold_asked <= hold_asked + 1;
        repeat (20)
            send_random_samples();
        wait_frames_out();
    endtask

    // Many phases, each with a fresh random register setting.
    task automatic test_random_settings();
        repeat (10)
        begin
            write_reg(REG_FORWARD_SPEED,      pick_reg_value(-32768, 32767, 16));
            write_reg(REG_PROP_GAIN,          pick_reg_value(0, 1023, 10));
            write_reg(REG_DERIV_GAIN,         pick_reg_value(-1024, 1023, 11));
            write_reg(REG_PRESENCE_THRESHOLD, pick_reg_value(0, 12287, 14));
            write_reg(REG_DEADBAND_Q8,        pick_reg_value(0, 12800, 14));
            write_reg(REG_BIAS_SCALE,         pick_reg_value(0, 127, 7));
            repeat (25)
                send_random_samples();
            wait_frames_out();
        end
    endtask

    // Main sequence: reset once, run each test in turn, let the block settle,
    // then report.
    initial
    begin
        mismatches   = 0;
        no_idle      = 1'b0;
        hold_asked   = 0;
        prev_bias_q8 = 0;
        shadow_cfg.forward_speed      = FORWARD_SPEED_RST;
        shadow_cfg.prop_gain          = PROP_GAIN_RST;
        shadow_cfg.deriv_gain         = DERIV_GAIN_RST;
        shadow_cfg.presence_threshold = PRESENCE_THRESHOLD_RST;
        shadow_cfg.deadband_q8        = DEADBAND_Q8_RST;
        shadow_cfg.bias_scale         = BIAS_SCALE_RST;

        rst_n                    <= 1'b0;
        samples_if.valid         <= 1'b0;
        samples_if.left_sample   <= '0;
        samples_if.middle_sample <= '0;
        samples_if.right_sample  <= '0;
        cfg_if.valid             <= 1'b0;
        cfg_if.index             <= REG_FORWARD_SPEED;
        cfg_if.data              <= '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_register_extremes();
        test_back_to_back();
        test_output_hold();
        test_random_settings();

        // All items are in and all frames are out; give the block time to show
        // any stray byte before the verdict.
        wait_frames_out();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("line_follow_pd_steering_framer_top verification clean");
        else
            $display("line_follow_pd_steering_framer_top verification failed");
        $finish;
    end

endmodule
